FILE: design/lrrc_pkg.sv
// Shared types, constants and the CRC-32 byte update for the log record replay checker.
`timescale 1ns / 1ps
`default_nettype none

package lrrc_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic REG_MAGIC   = 1'b0;
  localparam logic REG_VERSION = 1'b1;

  localparam int OPQ_DEPTH = 4;
  localparam int OPQ_AW    = 2;

  localparam int LEN_TOTAL_W = 33;

  typedef enum logic [1:0] {
    REQ_HEADER  = 2'd0,
    REQ_PAYLOAD = 2'd1,
    REQ_EOF     = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    OP_OPEN        = 3'd0,
    OP_BYTE        = 3'd1,
    OP_BAD_MAGIC   = 3'd2,
    OP_BAD_VERSION = 3'd3,
    OP_TRUNC       = 3'd4
  } op_t;

  localparam logic [2:0] VERDICT_ACCEPTED    = 3'd0;
  localparam logic [2:0] VERDICT_BAD_MAGIC   = 3'd1;
  localparam logic [2:0] VERDICT_BAD_VERSION = 3'd2;
  localparam logic [2:0] VERDICT_TRUNCATED   = 3'd3;
  localparam logic [2:0] VERDICT_CHECKSUM    = 3'd4;
  localparam logic [2:0] VERDICT_DUPLICATE   = 3'd5;

  typedef struct packed {
    op_t         op;
    logic        last;
    logic [7:0]  data;
    logic [63:0] seq;
    logic [2:0]  rtype;
    logic [31:0] len;
    logic [31:0] sum;
  } op_entry_t;

  typedef struct packed {
    logic                   finish;
    logic [2:0]             verdict;
    logic [31:0]            crc;
    logic [31:0]            sum;
    logic [63:0]            seq;
    logic [2:0]             rtype;
    logic [LEN_TOTAL_W-1:0] len_total;
  } judge_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic        gap;
    logic [63:0] seq;
    logic [2:0]  rtype;
    logic [31:0] corrupted;
    logic [31:0] replayed;
    logic [63:0] bytes;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (v[0]) begin
        v = (v >> 1) ^ CRC_POLY;
      end else begin
        v = v >> 1;
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: design/log_record_replay_checker.sv
// Top level of the log record replay checker.
// Throughput: one input beat per cycle, payload bytes included, while pop keeps up.
// Path: the beat that causes a result is registered in the op queue, then in the CRC stage,
// then in the judge stage's result queue, whose head drives the out_ ports.
// Reset (synchronous, rst_n low) clears framing state, the CRC, counters, queues and
// the expected magic and version registers; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module log_record_replay_checker
  import lrrc_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = 48
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [31:0] in_hdr_magic,
  input  wire logic [15:0] in_hdr_version,
  input  wire logic [63:0] in_hdr_sequence,
  input  wire logic [2:0]  in_hdr_entry_type,
  input  wire logic [31:0] in_hdr_payload_len,
  input  wire logic [31:0] in_hdr_checksum,
  input  wire logic [7:0]  in_payload_byte,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [2:0]       out_verdict,
  output logic             out_gap_seen,
  output logic [63:0]      out_record_sequence,
  output logic [2:0]       out_record_type,
  output logic [31:0]      out_corrupted_total,
  output logic [31:0]      out_replayed_total,
  output logic [63:0]      out_replayed_bytes
);

  logic      q_push, q_full, q_pop, q_empty;
  op_entry_t q_entry, q_head;
  logic      judge_valid, judge_take;
  judge_t    judge;
  result_t   result;

  lrrc_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_req_type        (in_req_type),
    .in_hdr_magic       (in_hdr_magic),
    .in_hdr_version     (in_hdr_version),
    .in_hdr_sequence    (in_hdr_sequence),
    .in_hdr_entry_type  (in_hdr_entry_type),
    .in_hdr_payload_len (in_hdr_payload_len),
    .in_hdr_checksum    (in_hdr_checksum),
    .in_payload_byte    (in_payload_byte),
    .q_push             (q_push),
    .q_entry            (q_entry),
    .q_full             (q_full)
  );

  lrrc_opq u_opq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  lrrc_crc #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_crc (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .judge_valid (judge_valid),
    .judge       (judge),
    .judge_take  (judge_take)
  );

  lrrc_judge u_judge (
    .clk         (clk),
    .rst_n       (rst_n),
    .judge_valid (judge_valid),
    .judge       (judge),
    .judge_take  (judge_take),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_result  (result)
  );

  assign out_verdict         = result.verdict;
  assign out_gap_seen        = result.gap;
  assign out_record_sequence = result.seq;
  assign out_record_type     = result.rtype;
  assign out_corrupted_total = result.corrupted;
  assign out_replayed_total  = result.replayed;
  assign out_replayed_bytes  = result.bytes;

endmodule

`default_nettype wire

FILE: design/lrrc_front.sv
// Front part: accepts input beats, tracks record framing and classifies each beat.
`timescale 1ns / 1ps
`default_nettype none

module lrrc_front
  import lrrc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [31:0] in_hdr_magic,
  input  wire logic [15:0] in_hdr_version,
  input  wire logic [63:0] in_hdr_sequence,
  input  wire logic [2:0]  in_hdr_entry_type,
  input  wire logic [31:0] in_hdr_payload_len,
  input  wire logic [31:0] in_hdr_checksum,
  input  wire logic [7:0]  in_payload_byte,
  output logic             q_push,
  output op_entry_t        q_entry,
  input  wire logic        q_full
);

  logic [31:0] magic_r, magic_nxt;
  logic [15:0] version_r, version_nxt;
  logic        in_payload_r, in_payload_nxt;
  logic        skip_r, skip_nxt;
  logic [31:0] left_r, left_nxt;
  logic        accept;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  always_comb begin
    magic_nxt   = magic_r;
    version_nxt = version_r;
    if (cfg_we) begin
      if (cfg_index == REG_MAGIC) begin
        magic_nxt = cfg_wdata;
      end else begin
        version_nxt = cfg_wdata[15:0];
      end
    end
  end

  always_comb begin
    in_payload_nxt = in_payload_r;
    skip_nxt       = skip_r;
    left_nxt       = left_r;
    q_push         = 1'b0;
    q_entry        = '0;
    q_entry.op     = OP_OPEN;
    q_entry.data   = in_payload_byte;
    q_entry.seq    = in_hdr_sequence;
    q_entry.rtype  = in_hdr_entry_type;
    q_entry.len    = in_hdr_payload_len;
    q_entry.sum    = in_hdr_checksum;
    if (accept) begin
      case (req_kind_t'(in_req_type))
        REQ_HEADER: begin
          if (!skip_r) begin
            q_push = 1'b1;
            if (in_payload_r) begin
              q_entry.op     = OP_TRUNC;
              in_payload_nxt = 1'b0;
              left_nxt       = '0;
              skip_nxt       = 1'b1;
            end else if (in_hdr_magic != magic_r) begin
              q_entry.op = OP_BAD_MAGIC;
              skip_nxt   = 1'b1;
            end else if (in_hdr_version != version_r) begin
              q_entry.op = OP_BAD_VERSION;
              skip_nxt   = 1'b1;
            end else begin
              q_entry.op = OP_OPEN;
              left_nxt   = in_hdr_payload_len;
              if (in_hdr_payload_len == '0) begin
                q_entry.last = 1'b1;
              end else begin
                in_payload_nxt = 1'b1;
              end
            end
          end
        end
        REQ_PAYLOAD: begin
          if (!skip_r && in_payload_r) begin
            q_push     = 1'b1;
            q_entry.op = OP_BYTE;
            left_nxt   = left_r - 32'd1;
            if (left_r == 32'd1) begin
              q_entry.last   = 1'b1;
              in_payload_nxt = 1'b0;
            end
          end
        end
        REQ_EOF: begin
          in_payload_nxt = 1'b0;
          skip_nxt       = 1'b0;
          left_nxt       = '0;
          if (in_payload_r && !skip_r) begin
            q_push     = 1'b1;
            q_entry.op = OP_TRUNC;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r      <= '0;
      version_r    <= '0;
      in_payload_r <= 1'b0;
      skip_r       <= 1'b0;
      left_r       <= '0;
    end else begin
      magic_r      <= magic_nxt;
      version_r    <= version_nxt;
      in_payload_r <= in_payload_nxt;
      skip_r       <= skip_nxt;
      left_r       <= left_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/lrrc_opq.sv
// Short queue of classified beats between the front part and the CRC stage.
`timescale 1ns / 1ps
`default_nettype none

module lrrc_opq
  import lrrc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire op_entry_t push_entry,
  output logic           full,
  input  wire logic      pop,
  output op_entry_t      head,
  output logic           empty
);

  op_entry_t         mem_r [OPQ_DEPTH];
  logic [OPQ_AW-1:0] wr_r, wr_nxt;
  logic [OPQ_AW-1:0] rd_r, rd_nxt;
  logic [OPQ_AW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (OPQ_AW+1)'(OPQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/lrrc_crc.sv
// CRC stage: holds the open record and runs one payload byte per cycle through CRC-32 while the judge keeps up.
`timescale 1ns / 1ps
`default_nettype none

module lrrc_crc
  import lrrc_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = 48
)
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      q_empty,
  input  wire op_entry_t q_head,
  output logic           q_pop,
  output logic           judge_valid,
  output judge_t         judge,
  input  wire logic      judge_take
);

  logic [31:0] crc_r, crc_nxt;
  logic [63:0] held_seq_r, held_seq_nxt;
  logic [31:0] held_sum_r, held_sum_nxt;
  logic [2:0]  held_type_r, held_type_nxt;
  logic [LEN_TOTAL_W-1:0] held_total_r, held_total_nxt;
  logic        jv_r, jv_nxt;
  judge_t      j_r, j_nxt;
  logic [31:0] crc_upd;

  assign q_pop       = !q_empty && (!jv_r || judge_take);
  assign judge_valid = jv_r;
  assign judge       = j_r;
  assign crc_upd     = crc_byte(crc_r, q_head.data);

  always_comb begin
    crc_nxt        = crc_r;
    held_seq_nxt   = held_seq_r;
    held_sum_nxt   = held_sum_r;
    held_type_nxt  = held_type_r;
    held_total_nxt = held_total_r;
    jv_nxt         = jv_r && !judge_take;
    j_nxt          = j_r;
    if (q_pop) begin
      j_nxt.finish    = 1'b1;
      j_nxt.verdict   = VERDICT_ACCEPTED;
      j_nxt.crc       = crc_r;
      j_nxt.sum       = held_sum_r;
      j_nxt.seq       = held_seq_r;
      j_nxt.rtype     = held_type_r;
      j_nxt.len_total = held_total_r;
      case (q_head.op)
        OP_OPEN: begin
          crc_nxt        = CRC_INIT;
          held_seq_nxt   = q_head.seq;
          held_sum_nxt   = q_head.sum;
          held_type_nxt  = q_head.rtype;
          held_total_nxt = {1'b0, q_head.len} + LEN_TOTAL_W'(HEADER_BYTES);
          if (q_head.last) begin
            jv_nxt          = 1'b1;
            j_nxt.crc       = CRC_INIT;
            j_nxt.sum       = q_head.sum;
            j_nxt.seq       = q_head.seq;
            j_nxt.rtype     = q_head.rtype;
            j_nxt.len_total = LEN_TOTAL_W'(HEADER_BYTES);
          end
        end
        OP_BYTE: begin
          if (q_head.last) begin
            crc_nxt   = CRC_INIT;
            jv_nxt    = 1'b1;
            j_nxt.crc = crc_upd;
          end else begin
            crc_nxt = crc_upd;
          end
        end
        OP_BAD_MAGIC: begin
          jv_nxt        = 1'b1;
          j_nxt.finish  = 1'b0;
          j_nxt.verdict = VERDICT_BAD_MAGIC;
          j_nxt.seq     = q_head.seq;
          j_nxt.rtype   = q_head.rtype;
        end
        OP_BAD_VERSION: begin
          jv_nxt        = 1'b1;
          j_nxt.finish  = 1'b0;
          j_nxt.verdict = VERDICT_BAD_VERSION;
          j_nxt.seq     = q_head.seq;
          j_nxt.rtype   = q_head.rtype;
        end
        OP_TRUNC: begin
          crc_nxt       = CRC_INIT;
          jv_nxt        = 1'b1;
          j_nxt.finish  = 1'b0;
          j_nxt.verdict = VERDICT_TRUNCATED;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    j_r <= j_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r        <= CRC_INIT;
      held_seq_r   <= '0;
      held_sum_r   <= '0;
      held_type_r  <= '0;
      held_total_r <= '0;
      jv_r         <= 1'b0;
    end else begin
      crc_r        <= crc_nxt;
      held_seq_r   <= held_seq_nxt;
      held_sum_r   <= held_sum_nxt;
      held_type_r  <= held_type_nxt;
      held_total_r <= held_total_nxt;
      jv_r         <= jv_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/lrrc_judge.sv
// Judge stage: decides each record's verdict, keeps the counters and queues the results.
`timescale 1ns / 1ps
`default_nettype none

module lrrc_judge
  import lrrc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   judge_valid,
  input  wire judge_t judge,
  output logic        judge_take,
  output logic        out_empty,
  input  wire logic   out_pop,
  output result_t     out_result
);

  logic [63:0] last_r, last_nxt;
  logic [63:0] last_p1_r, last_p1_nxt;
  logic        last_nz_r, last_nz_nxt;
  logic [31:0] corrupt_r, corrupt_nxt;
  logic [31:0] accept_r, accept_nxt;
  logic [63:0] bytes_r, bytes_nxt;
  result_t     res;
  result_t     mem_r [2];
  logic        wr_r, rd_r;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        do_pop;

  assign judge_take = judge_valid && (cnt_r != 2'd2);
  assign out_empty  = (cnt_r == 2'd0);
  assign do_pop     = out_pop && !out_empty;
  assign out_result = mem_r[rd_r];

  always_comb begin
    last_nxt    = last_r;
    last_p1_nxt = last_p1_r;
    last_nz_nxt = last_nz_r;
    corrupt_nxt = corrupt_r;
    accept_nxt  = accept_r;
    bytes_nxt   = bytes_r;
    res.verdict = judge.verdict;
    res.gap     = 1'b0;
    res.seq     = judge.seq;
    res.rtype   = judge.rtype;
    if (judge_take) begin
      if (!judge.finish) begin
        corrupt_nxt = corrupt_r + 32'd1;
      end else if (~judge.crc != judge.sum) begin
        res.verdict = VERDICT_CHECKSUM;
        corrupt_nxt = corrupt_r + 32'd1;
      end else if (judge.seq <= last_r) begin
        res.verdict = VERDICT_DUPLICATE;
      end else begin
        res.verdict = VERDICT_ACCEPTED;
        res.gap     = last_nz_r && (judge.seq != last_p1_r);
        accept_nxt  = accept_r + 32'd1;
        bytes_nxt   = bytes_r + {{(64-LEN_TOTAL_W){1'b0}}, judge.len_total};
        last_nxt    = judge.seq;
        last_p1_nxt = judge.seq + 64'd1;
        last_nz_nxt = 1'b1;
      end
    end
    res.corrupted = corrupt_nxt;
    res.replayed  = accept_nxt;
    res.bytes     = bytes_nxt;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (judge_take && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !judge_take) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (judge_take) begin
      mem_r[wr_r] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r    <= '0;
      last_p1_r <= 64'd1;
      last_nz_r <= 1'b0;
      corrupt_r <= '0;
      accept_r  <= '0;
      bytes_r   <= '0;
      wr_r      <= 1'b0;
      rd_r      <= 1'b0;
      cnt_r     <= '0;
    end else begin
      last_r    <= last_nxt;
      last_p1_r <= last_p1_nxt;
      last_nz_r <= last_nz_nxt;
      corrupt_r <= corrupt_nxt;
      accept_r  <= accept_nxt;
      bytes_r   <= bytes_nxt;
      wr_r      <= judge_take ? ~wr_r : wr_r;
      rd_r      <= do_pop ? ~rd_r : rd_r;
      cnt_r     <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire
